### design/fbr_pkg.sv
// ----------------------------------------------------------------------------
// fbr_pkg
// Shared types and constants for the floppy track bit rotator.
// ----------------------------------------------------------------------------
package fbr_pkg;

  localparam logic [1:0] REQ_ROTATE   = 2'd0;
  localparam logic [1:0] REQ_LOAD_MAP = 2'd1;
  localparam logic [1:0] REQ_LOAD_LEN = 2'd2;
  localparam logic [1:0] REQ_LOAD_BYTE = 2'd3;

  localparam logic [7:0] EMPTY_ENTRY = 8'hFF;

  localparam int POS_W = 19;
  localparam int LEN_W = 16;
  localparam int PROD_W = POS_W + LEN_W;
  localparam int NUM_W = PROD_W + 2;
  localparam int DEN_W = LEN_W + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int TOL_W = 30;
  localparam logic [TOL_W-1:0] RESCALE_TOL = 30'd10000;

  typedef struct packed {
    logic map_we;
    logic map_re;
    logic len_we;
    logic len_re;
    logic byte_we;
    logic byte_re;
  } store_ctl_t;

endpackage

### design/fbr_if.sv
// ----------------------------------------------------------------------------
// fbr_if
// Valid/ready channels: request input, result output, configuration write.
// ----------------------------------------------------------------------------
interface fbr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  quarter_track;
  logic [5:0]  track_index;
  logic [12:0] byte_address;
  logic [15:0] load_value;

  modport source (output valid, output req_type, output quarter_track,
                  output track_index, output byte_address, output load_value,
                  input ready);
  modport sink (input valid, input req_type, input quarter_track,
                input track_index, input byte_address, input load_value,
                output ready);
endinterface

interface fbr_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic track_present;
  logic illegal_track;

  modport source (output valid, output data_bit, output track_present,
                  output illegal_track, input ready);
  modport sink (input valid, input data_bit, input track_present,
                input illegal_track, output ready);
endinterface

interface fbr_cfg_if;
  logic valid;
  logic ready;
  logic disk_loaded;

  modport source (output valid, output disk_loaded, input ready);
  modport sink (input valid, input disk_loaded, output ready);
endinterface

### design/floppy_track_bit_rotator_core.sv
// A load transaction passes through the decode and done states before its result
// is registered; a rotate also walks the chain of registered memory reads.
// A track change with rescale adds a pass through the 37-step divider.
// One transaction in flight; the next is taken once the result is
// registered. Reset clears the sequencer, head position and map valid bits.
// ----------------------------------------------------------------------------
// floppy_track_bit_rotator_core
// Floppy head over circular bit tracks: sequencer, storage and divider.
// ----------------------------------------------------------------------------
module floppy_track_bit_rotator_core #(
  parameter int QUARTER_TRACKS = 160,
  parameter int MAX_TRACKS     = 64,
  parameter int TRACK_BYTES    = 8192
) (
  input  logic      clk,
  input  logic      rst_n,
  fbr_in_if.sink    in_ch,
  fbr_out_if.source out_ch,
  fbr_cfg_if.sink   cfg_ch
);
  import fbr_pkg::*;

  localparam int MAP_AW  = $clog2(QUARTER_TRACKS);
  localparam int LEN_AW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int BYTE_AW = $clog2(MAX_TRACKS * TRACK_BYTES);

  store_ctl_t         st_ctl;
  logic [MAP_AW-1:0]  map_waddr, map_raddr;
  logic [7:0]         map_wdata, map_entry;
  logic [LEN_AW-1:0]  len_waddr, len_raddr;
  logic [LEN_W-1:0]   len_wdata, len_q;
  logic [BYTE_AW-1:0] byte_waddr, byte_raddr;
  logic [7:0]         byte_wdata, byte_q;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [POS_W-1:0]   div_quo;

  fbr_seq #(
    .QUARTER_TRACKS(QUARTER_TRACKS), .MAX_TRACKS(MAX_TRACKS),
    .TRACK_BYTES(TRACK_BYTES), .MAP_AW(MAP_AW), .LEN_AW(LEN_AW),
    .BYTE_AW(BYTE_AW)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .st_ctl(st_ctl),
    .map_waddr(map_waddr), .map_raddr(map_raddr), .map_wdata(map_wdata),
    .map_entry(map_entry),
    .len_waddr(len_waddr), .len_raddr(len_raddr), .len_wdata(len_wdata),
    .len_q(len_q),
    .byte_waddr(byte_waddr), .byte_raddr(byte_raddr), .byte_wdata(byte_wdata),
    .byte_q(byte_q),
    .div_start(div_start), .div_num(div_num), .div_den(div_den),
    .div_done(div_done), .div_quo(div_quo)
  );

  fbr_store #(
    .QUARTER_TRACKS(QUARTER_TRACKS), .MAX_TRACKS(MAX_TRACKS),
    .TRACK_BYTES(TRACK_BYTES), .MAP_AW(MAP_AW), .LEN_AW(LEN_AW),
    .BYTE_AW(BYTE_AW)
  ) u_store (
    .clk(clk), .rst_n(rst_n), .ctl(st_ctl),
    .map_waddr(map_waddr), .map_raddr(map_raddr), .map_wdata(map_wdata),
    .map_entry(map_entry),
    .len_waddr(len_waddr), .len_raddr(len_raddr), .len_wdata(len_wdata),
    .len_q(len_q),
    .byte_waddr(byte_waddr), .byte_raddr(byte_raddr), .byte_wdata(byte_wdata),
    .byte_q(byte_q)
  );

  fbr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

endmodule

### design/fbr_store.sv
// ----------------------------------------------------------------------------
// fbr_store
// Disk image storage: quarter-track map, track lengths, track bytes.
// ----------------------------------------------------------------------------
module fbr_store #(
  parameter int QUARTER_TRACKS = 160,
  parameter int MAX_TRACKS     = 64,
  parameter int TRACK_BYTES    = 8192,
  parameter int MAP_AW         = 8,
  parameter int LEN_AW         = 6,
  parameter int BYTE_AW        = 19
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fbr_pkg::store_ctl_t      ctl,
  input  logic [MAP_AW-1:0]        map_waddr,
  input  logic [MAP_AW-1:0]        map_raddr,
  input  logic [7:0]               map_wdata,
  output logic [7:0]               map_entry,
  input  logic [LEN_AW-1:0]        len_waddr,
  input  logic [LEN_AW-1:0]        len_raddr,
  input  logic [fbr_pkg::LEN_W-1:0] len_wdata,
  output logic [fbr_pkg::LEN_W-1:0] len_q,
  input  logic [BYTE_AW-1:0]       byte_waddr,
  input  logic [BYTE_AW-1:0]       byte_raddr,
  input  logic [7:0]               byte_wdata,
  output logic [7:0]               byte_q
);
  import fbr_pkg::*;

  localparam int BYTE_DEPTH = MAX_TRACKS * TRACK_BYTES;

  logic [7:0]       map_mem [QUARTER_TRACKS];
  logic [LEN_W-1:0] len_mem [MAX_TRACKS];
  logic [7:0]       byte_mem [BYTE_DEPTH];

  logic [QUARTER_TRACKS-1:0] map_vld_r;
  logic [7:0]                map_q_r;
  logic                      map_vld_q_r;
  logic [LEN_W-1:0]          len_q_r;
  logic [7:0]                byte_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r <= '0;
    end else if (ctl.map_we) begin
      map_vld_r[map_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (ctl.map_re) begin
      map_q_r     <= map_mem[map_raddr];
      map_vld_q_r <= map_vld_r[map_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (ctl.len_re) begin
      len_q_r <= len_mem[len_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.byte_we) begin
      byte_mem[byte_waddr] <= byte_wdata;
    end
    if (ctl.byte_re) begin
      byte_q_r <= byte_mem[byte_raddr];
    end
  end

  assign map_entry = map_vld_q_r ? map_q_r : EMPTY_ENTRY;
  assign len_q     = len_q_r;
  assign byte_q    = byte_q_r;

endmodule

### design/fbr_div.sv
// ----------------------------------------------------------------------------
// fbr_div
// Restoring divider, one quotient bit per cycle, low position bits returned.
// ----------------------------------------------------------------------------
module fbr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fbr_pkg::NUM_W-1:0] num,
  input  logic [fbr_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [fbr_pkg::POS_W-1:0] quo
);
  import fbr_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [POS_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = qbit ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[POS_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### design/fbr_seq.sv
// ----------------------------------------------------------------------------
// fbr_seq
// Request sequencer: decodes transactions, walks the store reads, rescales
// and wraps the head position, and holds the result register.
// ----------------------------------------------------------------------------
module fbr_seq #(
  parameter int QUARTER_TRACKS = 160,
  parameter int MAX_TRACKS     = 64,
  parameter int TRACK_BYTES    = 8192,
  parameter int MAP_AW         = 8,
  parameter int LEN_AW         = 6,
  parameter int BYTE_AW        = 19
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fbr_in_if.sink                     in_ch,
  fbr_out_if.source                  out_ch,
  fbr_cfg_if.sink                    cfg_ch,
  output fbr_pkg::store_ctl_t        st_ctl,
  output logic [MAP_AW-1:0]          map_waddr,
  output logic [MAP_AW-1:0]          map_raddr,
  output logic [7:0]                 map_wdata,
  input  logic [7:0]                 map_entry,
  output logic [LEN_AW-1:0]          len_waddr,
  output logic [LEN_AW-1:0]          len_raddr,
  output logic [fbr_pkg::LEN_W-1:0]  len_wdata,
  input  logic [fbr_pkg::LEN_W-1:0]  len_q,
  output logic [BYTE_AW-1:0]         byte_waddr,
  output logic [BYTE_AW-1:0]         byte_raddr,
  output logic [7:0]                 byte_wdata,
  input  logic [7:0]                 byte_q,
  output logic                       div_start,
  output logic [fbr_pkg::NUM_W-1:0]  div_num,
  output logic [fbr_pkg::DEN_W-1:0]  div_den,
  input  logic                       div_done,
  input  logic [fbr_pkg::POS_W-1:0]  div_quo
);
  import fbr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_MAP   = 4'd2;
  localparam logic [3:0] S_PMAP  = 4'd3;
  localparam logic [3:0] S_OLEN  = 4'd4;
  localparam logic [3:0] S_NLEN  = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_DIVGO = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_LEN   = 4'd9;
  localparam logic [3:0] S_WRAP  = 4'd10;
  localparam logic [3:0] S_BYTE  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam logic [BYTE_AW-1:0] TB_C = BYTE_AW'(TRACK_BYTES);

  logic [3:0]         state_r, state_nxt;
  logic               disk_r;
  logic [1:0]         req_r;
  logic [7:0]         qt_r;
  logic [5:0]         ti_r;
  logic [12:0]        addr_r;
  logic [15:0]        val_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         prev_qt_r, prev_qt_nxt;
  logic [7:0]         slot_r, slot_nxt;
  logic [BYTE_AW-1:0] base_r, base_nxt;
  logic [LEN_W-1:0]   old_len_r, old_len_nxt;
  logic [LEN_W-1:0]   new_len_r, new_len_nxt;
  logic [LEN_W-1:0]   diff_r, diff_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               res_bit_r, res_bit_nxt;
  logic               res_pres_r, res_pres_nxt;
  logic               res_ill_r, res_ill_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_bit_r, out_pres_r, out_ill_r;
  logic               accept, out_free;
  logic               entry_ok;
  logic [7:0]         eff_prev;
  logic [POS_W-1:0]   pos_wrap;
  logic [15:0]        byte_idx;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign entry_ok = (32'(map_entry) < MAX_TRACKS);
  assign eff_prev = (32'(prev_qt_r) >= QUARTER_TRACKS) ? qt_r : prev_qt_r;
  assign pos_wrap = ({3'd0, new_len_r} <= pos_r) ? '0 : pos_r;
  assign byte_idx = pos_wrap[POS_W-1:3];

  assign map_waddr  = MAP_AW'(qt_r);
  assign map_wdata  = val_r[7:0];
  assign len_waddr  = LEN_AW'(ti_r);
  assign len_wdata  = val_r;
  assign byte_waddr = BYTE_AW'(BYTE_AW'(ti_r) * TB_C + BYTE_AW'(addr_r));
  assign byte_wdata = val_r[7:0];
  assign div_num    = NUM_W'({prod_r, 1'b0}) + NUM_W'(old_len_r);
  assign div_den    = {old_len_r, 1'b0};

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    prev_qt_nxt   = prev_qt_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    old_len_nxt   = old_len_r;
    new_len_nxt   = new_len_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    res_bit_nxt   = res_bit_r;
    res_pres_nxt  = res_pres_r;
    res_ill_nxt   = res_ill_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    st_ctl        = '0;
    map_raddr     = MAP_AW'(qt_r);
    len_raddr     = LEN_AW'(slot_r);
    byte_raddr    = BYTE_AW'(base_r + BYTE_AW'(byte_idx));
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_bit_nxt  = 1'b0;
          res_pres_nxt = 1'b0;
          res_ill_nxt  = 1'b0;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_DONE;
        case (req_r)
          REQ_ROTATE: begin
            if (disk_r) begin
              if (32'(qt_r) >= QUARTER_TRACKS) begin
                res_ill_nxt = 1'b1;
              end else begin
                pos_nxt       = pos_r + 1'b1;
                st_ctl.map_re = 1'b1;
                state_nxt     = S_MAP;
              end
            end
          end
          REQ_LOAD_MAP: begin
            st_ctl.map_we = (32'(qt_r) < QUARTER_TRACKS);
          end
          REQ_LOAD_LEN: begin
            st_ctl.len_we = (32'(ti_r) < MAX_TRACKS);
          end
          REQ_LOAD_BYTE: begin
            st_ctl.byte_we = (32'(ti_r) < MAX_TRACKS) && (32'(addr_r) < TRACK_BYTES);
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MAP: begin
        slot_nxt = map_entry;
        base_nxt = BYTE_AW'(BYTE_AW'(map_entry) * TB_C);
        if (!entry_ok) begin
          state_nxt = S_DONE;
        end else begin
          res_pres_nxt = 1'b1;
          prev_qt_nxt  = qt_r;
          if (qt_r != eff_prev) begin
            map_raddr     = MAP_AW'(eff_prev);
            st_ctl.map_re = 1'b1;
            state_nxt     = S_PMAP;
          end else begin
            len_raddr     = LEN_AW'(map_entry);
            st_ctl.len_re = 1'b1;
            state_nxt     = S_LEN;
          end
        end
      end
      S_PMAP: begin
        st_ctl.len_re = 1'b1;
        if (entry_ok) begin
          len_raddr = LEN_AW'(map_entry);
          state_nxt = S_OLEN;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_OLEN: begin
        old_len_nxt   = len_q;
        st_ctl.len_re = 1'b1;
        state_nxt     = S_NLEN;
      end
      S_NLEN: begin
        new_len_nxt = len_q;
        diff_nxt    = (old_len_r > len_q) ? old_len_r - len_q : len_q - old_len_r;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        if ((old_len_r == '0) ||
            (TOL_W'(diff_r) * RESCALE_TOL < TOL_W'(old_len_r))) begin
          state_nxt = S_WRAP;
        end else begin
          prod_nxt  = PROD_W'(pos_r) * PROD_W'(new_len_r);
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          pos_nxt   = div_quo;
          state_nxt = S_WRAP;
        end
      end
      S_LEN: begin
        new_len_nxt = len_q;
        state_nxt   = S_WRAP;
      end
      S_WRAP: begin
        pos_nxt = pos_wrap;
        if (32'(byte_idx) < TRACK_BYTES) begin
          st_ctl.byte_re = 1'b1;
          state_nxt      = S_BYTE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BYTE: begin
        res_bit_nxt = byte_q[~pos_r[2:0]];
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      disk_r      <= 1'b0;
      pos_r       <= '0;
      prev_qt_r   <= 8'(QUARTER_TRACKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      prev_qt_r   <= prev_qt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        disk_r <= cfg_ch.disk_loaded;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_ch.req_type;
      qt_r   <= in_ch.quarter_track;
      ti_r   <= in_ch.track_index;
      addr_r <= in_ch.byte_address;
      val_r  <= in_ch.load_value;
    end
    slot_r     <= slot_nxt;
    base_r     <= base_nxt;
    old_len_r  <= old_len_nxt;
    new_len_r  <= new_len_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    res_bit_r  <= res_bit_nxt;
    res_pres_r <= res_pres_nxt;
    res_ill_r  <= res_ill_nxt;
    if (state_r == S_DONE && out_free) begin
      out_bit_r  <= res_bit_r;
      out_pres_r <= res_pres_r;
      out_ill_r  <= res_ill_r;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_bit      = out_bit_r;
  assign out_ch.track_present = out_pres_r;
  assign out_ch.illegal_track = out_ill_r;

endmodule

### design/fbr_checker.sv
// ----------------------------------------------------------------------------
// fbr_checker
// Port-level checks for the floppy track bit rotator, bound to the top level.
// ----------------------------------------------------------------------------
module fbr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic data_bit,
  input logic track_present,
  input logic illegal_track
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({data_bit, track_present, illegal_track}))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(track_present && illegal_track))
    else $error("present and illegal both set");

  a_bit_needs_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !track_present |-> !data_bit)
    else $error("data bit set without a track");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind floppy_track_bit_rotator_core fbr_checker u_fbr_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .data_bit(out_ch.data_bit),
  .track_present(out_ch.track_present),
  .illegal_track(out_ch.illegal_track)
);
